// ----- hdl/pgs_pkg.sv -----
// Shared types and constants of the PageRank Gauss-Seidel engine.
// Used by the divider, controller, datapath, top level and testbench; no dependencies.
`default_nettype none

package pgs_pkg;

    localparam int NODE_AW   = 12;
    localparam int EDGE_AW   = 16;
    localparam int MAX_NODES = 1 << NODE_AW;
    localparam int MAX_EDGES = 1 << EDGE_AW;
    localparam int NCNT_W    = NODE_AW + 1;
    localparam int ECNT_W    = EDGE_AW + 1;
    localparam int RANK_W    = 32;
    localparam int DAMP_W    = 16;
    localparam int ITER_W    = 16;
    localparam int SUM_W     = RANK_W + EDGE_AW + 1;

    typedef enum logic [1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_RUN      = 2'd1,
        OP_READ     = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_NOCONV = 2'd3
    } status_t;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_DAMPING    = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;
    localparam logic [1:0] CFG_MAX_ITER   = 2'd3;

    typedef enum logic [4:0] {
        S_CLEAR, S_CLEAR_OP, S_IDLE, S_ADD2, S_READ2,
        S_EDIV, S_TELE, S_INIT,
        S_CNT1, S_CNT2, S_CNT3,
        S_PFX1, S_PFX2,
        S_PLC1, S_PLC2, S_PLC3,
        S_W1, S_W2, S_WDIV,
        S_E1, S_E2, S_E3, S_EDIV2,
        S_FIN, S_MUL, S_NV, S_SWEEP_END,
        S_RESP
    } step_t;

    typedef struct packed {
        step_t step;
        logic  accept;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic add_ok;
        logic read_ok;
        logic clr_last;
        logic node_end;
        logic edge_end;
        logic edge_valid;
        logic odeg_zero;
        logic rem_zero;
        logic div_done;
        logic sweep_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/pgs_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pgs_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/pgs_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on pgs_pkg for widths.
`default_nettype none

module pgs_divider
    import pgs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RANK_W-1:0] dividend,
    input  wire logic [ECNT_W-1:0] divisor,
    output logic                   done,
    output logic      [RANK_W-1:0] quotient
);

    localparam int CNT_W = $clog2(RANK_W + 1);

    logic [ECNT_W-1:0] rem_reg;
    logic [RANK_W-1:0] quo_reg;
    logic [ECNT_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ECNT_W:0]   shifted;
    logic [ECNT_W+1:0] trial;
    logic              fits;

    assign shifted  = {rem_reg, quo_reg[RANK_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits     = ~trial[ECNT_W+1];
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(RANK_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? trial[ECNT_W-1:0] : shifted[ECNT_W-1:0];
                quo_reg <= {quo_reg[RANK_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pgs_ctrl.sv -----
// Sequencing state machine: steps the datapath through loads, runs, reads and clears.
// Depends on pgs_pkg for the step, command and status types.
`default_nettype none

module pgs_ctrl
    import pgs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    step_t state_reg;
    step_t state_next;

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.step   = state_reg;
    assign cmd.accept = s_tready && s_tvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (status.clr_last) state_next = S_IDLE;
            S_CLEAR_OP: if (status.clr_last) state_next = S_RESP;
            S_IDLE: begin
                if (cmd.accept) begin
                    unique case (status.op)
                        OP_ADD_EDGE: state_next = status.add_ok ? S_ADD2 : S_RESP;
                        OP_RUN:      state_next = S_EDIV;
                        OP_READ:     state_next = status.read_ok ? S_READ2 : S_RESP;
                        default:     state_next = S_CLEAR_OP;
                    endcase
                end
            end
            S_ADD2, S_READ2: state_next = S_RESP;
            S_EDIV:  if (status.div_done) state_next = S_TELE;
            S_TELE:  state_next = S_INIT;
            S_INIT:  if (status.node_end) state_next = S_CNT1;
            S_CNT1:  state_next = status.edge_end ? S_PFX1 : S_CNT2;
            S_CNT2:  state_next = status.edge_valid ? S_CNT3 : S_CNT1;
            S_CNT3:  state_next = S_CNT1;
            S_PFX1:  state_next = status.node_end ? S_PLC1 : S_PFX2;
            S_PFX2:  state_next = S_PFX1;
            S_PLC1:  state_next = status.edge_end ? S_W1 : S_PLC2;
            S_PLC2:  state_next = status.edge_valid ? S_PLC3 : S_PLC1;
            S_PLC3:  state_next = S_PLC1;
            S_W1:    state_next = status.node_end ? S_SWEEP_END : S_W2;
            S_W2:    state_next = status.odeg_zero ? S_WDIV : S_E1;
            S_WDIV:  if (status.div_done) state_next = S_E1;
            S_E1:    state_next = status.rem_zero ? S_FIN : S_E2;
            S_E2:    state_next = S_E3;
            S_E3:    state_next = status.odeg_zero ? S_E1 : S_EDIV2;
            S_EDIV2: if (status.div_done) state_next = S_E1;
            S_FIN:   state_next = S_MUL;
            S_MUL:   state_next = S_NV;
            S_NV:    state_next = S_W1;
            S_SWEEP_END: state_next = status.sweep_done ? S_RESP : S_W1;
            S_RESP:  if (status.out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/pgs_datapath.sv -----
// Datapath: configuration registers, graph and rank memories, divider,
// accumulators and the result register. Depends on pgs_pkg, pgs_ram, pgs_divider.
`default_nettype none

module pgs_datapath
    import pgs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ctrl_cmd_t         cmd,
    output dp_status_t             status,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_wdata,
    input  wire logic [1:0]        operation,
    input  wire logic [NODE_AW-1:0] source_node,
    input  wire logic [NODE_AW-1:0] target_node,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [1:0]             res_status,
    output logic [RANK_W-1:0]      res_rank,
    output logic [ITER_W-1:0]      res_sweeps,
    output logic [RANK_W-1:0]      res_change
);

    function automatic logic [RANK_W-1:0] sat32(input logic [SUM_W-1:0] v);
        sat32 = (v > SUM_W'({RANK_W{1'b1}})) ? {RANK_W{1'b1}} : v[RANK_W-1:0];
    endfunction

    // configuration
    logic [NCNT_W-1:0] node_count_reg;
    logic [DAMP_W-1:0] damping_reg;
    logic [RANK_W-1:0] threshold_reg;
    logic [ITER_W-1:0] max_iter_reg;

    // control state
    logic [ECNT_W-1:0]  total_reg;
    logic [NODE_AW-1:0] clr_reg;
    logic [NCNT_W-1:0]  k_reg;
    logic [ECNT_W-1:0]  i_reg;
    logic [ECNT_W-1:0]  j_reg;
    logic [ECNT_W-1:0]  rem_reg;
    logic [ECNT_W-1:0]  acc_reg;
    logic [ITER_W-1:0]  sweeps_reg;
    logic               ok_reg;
    logic               m_tvalid_reg;

    // payload
    logic [NODE_AW-1:0] src_reg, tgt_reg;
    logic [RANK_W-1:0]  e_reg, tele_reg, dm_reg, old_reg, ssat_reg, worst_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [RANK_W:0]    ndang_reg;
    logic [RANK_W+DAMP_W-1:0] prod_reg;
    logic [1:0]         res_status_reg;
    logic [RANK_W-1:0]  res_rank_reg, out_rank_reg, out_change_reg, stat_change_reg;
    logic [1:0]         out_status_reg;
    logic [ITER_W-1:0]  out_sweeps_reg, stat_sweeps_reg;

    // memory ports
    logic                   edge_we, odeg_we, cnt_we, fill_we, list_we, rank_we;
    logic [EDGE_AW-1:0]     list_waddr;
    logic [NODE_AW-1:0]     odeg_waddr, cnt_waddr, fill_waddr, rank_waddr;
    logic [NODE_AW-1:0]     odeg_raddr, cnt_raddr, fill_raddr, rank_raddr;
    logic [ECNT_W-1:0]      odeg_wdata, cnt_wdata, fill_wdata;
    logic [RANK_W-1:0]      rank_wdata;
    logic [2*NODE_AW-1:0]   edge_rdata;
    logic [ECNT_W-1:0]      odeg_rdata, cnt_rdata, fill_rdata;
    logic [NODE_AW-1:0]     list_rdata;
    logic [RANK_W-1:0]      rank_rdata;

    logic [NCNT_W-1:0]  n_eff;
    logic [NODE_AW-1:0] e_src, e_tgt;
    logic               div_start, div_done;
    logic [RANK_W-1:0]  div_dividend, div_quotient;
    logic [ECNT_W-1:0]  div_divisor;
    logic [RANK_W:0]    nv_sum;
    logic [RANK_W-1:0]  nv, diff;
    logic [ITER_W:0]    cap, sweeps_inc;
    logic               out_free, range_add, store_full;
    logic [DAMP_W:0]    one_minus_d;
    logic [DAMP_W+RANK_W:0] tele_prod;

    assign n_eff = (node_count_reg == '0) ? NCNT_W'(1)
                 : (node_count_reg > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES)
                 : node_count_reg;
    assign e_src = edge_rdata[NODE_AW-1:0];
    assign e_tgt = edge_rdata[2*NODE_AW-1:NODE_AW];

    assign range_add  = ({1'b0, source_node} < n_eff) && ({1'b0, target_node} < n_eff);
    assign store_full = (total_reg == ECNT_W'(MAX_EDGES));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cap        = (max_iter_reg == '0) ? (ITER_W+1)'(1) : {1'b0, max_iter_reg};
    assign sweeps_inc = {1'b0, sweeps_reg} + (ITER_W+1)'(1);

    assign nv_sum = {1'b0, prod_reg[RANK_W+DAMP_W-1:DAMP_W]} + {1'b0, tele_reg};
    assign nv     = nv_sum[RANK_W] ? {RANK_W{1'b1}} : nv_sum[RANK_W-1:0];
    assign diff   = (nv >= old_reg) ? nv - old_reg : old_reg - nv;

    assign one_minus_d = (DAMP_W+1)'(1 << DAMP_W) - {1'b0, damping_reg};
    assign tele_prod   = one_minus_d * {1'b0, e_reg};

    always_comb begin
        status.op         = op_t'(operation);
        status.add_ok     = range_add && !store_full;
        status.read_ok    = ({1'b0, target_node} < n_eff);
        status.clr_last   = (clr_reg == NODE_AW'(MAX_NODES - 1));
        status.node_end   = (k_reg == n_eff);
        status.edge_end   = (i_reg == total_reg);
        status.edge_valid = ({1'b0, e_src} < n_eff) && ({1'b0, e_tgt} < n_eff);
        status.odeg_zero  = (odeg_rdata == '0);
        status.rem_zero   = (rem_reg == '0);
        status.div_done   = div_done;
        status.sweep_done = ok_reg || (sweeps_inc >= cap);
        status.out_free   = out_free;
    end

    // memory port selection
    always_comb begin
        edge_we    = cmd.accept && (status.op == OP_ADD_EDGE) && status.add_ok;
        odeg_we    = 1'b0;
        odeg_waddr = clr_reg;
        odeg_wdata = '0;
        cnt_we     = 1'b0;
        cnt_waddr  = k_reg[NODE_AW-1:0];
        cnt_wdata  = '0;
        fill_we    = 1'b0;
        fill_waddr = k_reg[NODE_AW-1:0];
        fill_wdata = acc_reg;
        list_we    = 1'b0;
        list_waddr = fill_rdata[EDGE_AW-1:0];
        rank_we    = 1'b0;
        rank_waddr = k_reg[NODE_AW-1:0];
        rank_wdata = e_reg;
        odeg_raddr = k_reg[NODE_AW-1:0];
        cnt_raddr  = k_reg[NODE_AW-1:0];
        fill_raddr = e_tgt;
        rank_raddr = k_reg[NODE_AW-1:0];
        unique case (cmd.step)
            S_CLEAR, S_CLEAR_OP: odeg_we = 1'b1;
            S_IDLE: begin
                odeg_raddr = source_node;
                rank_raddr = target_node;
            end
            S_ADD2: begin
                odeg_we    = 1'b1;
                odeg_waddr = src_reg;
                odeg_wdata = odeg_rdata + ECNT_W'(1);
            end
            S_INIT: begin
                cnt_we  = !status.node_end;
                rank_we = !status.node_end;
            end
            S_CNT2: cnt_raddr = e_tgt;
            S_CNT3: begin
                cnt_we    = 1'b1;
                cnt_waddr = tgt_reg;
                cnt_wdata = cnt_rdata + ECNT_W'(1);
            end
            S_PFX2: fill_we = 1'b1;
            S_PLC3: begin
                fill_we    = 1'b1;
                fill_waddr = tgt_reg;
                fill_wdata = fill_rdata + ECNT_W'(1);
                list_we    = 1'b1;
            end
            S_E2: begin
                odeg_raddr = list_rdata;
                rank_raddr = list_rdata;
            end
            S_NV: begin
                rank_we    = 1'b1;
                rank_wdata = nv;
            end
            default: ;
        endcase
    end

    // divider operand selection
    always_comb begin
        div_start    = 1'b0;
        div_dividend = RANK_W'(1 << 30);
        div_divisor  = ECNT_W'(n_eff);
        if (cmd.accept && (status.op == OP_RUN)) begin
            div_start = 1'b1;
        end else if ((cmd.step == S_W2) && status.odeg_zero) begin
            div_start    = 1'b1;
            div_dividend = rank_rdata;
        end else if ((cmd.step == S_E3) && !status.odeg_zero) begin
            div_start    = 1'b1;
            div_dividend = rank_rdata;
            div_divisor  = odeg_rdata;
        end
    end

    pgs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    pgs_ram #(.W(2*NODE_AW), .D(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(edge_we), .waddr(total_reg[EDGE_AW-1:0]),
        .wdata({target_node, source_node}), .raddr(i_reg[EDGE_AW-1:0]), .rdata(edge_rdata)
    );
    pgs_ram #(.W(ECNT_W), .D(MAX_NODES)) u_odeg_ram (
        .aclk(aclk), .we(odeg_we), .waddr(odeg_waddr), .wdata(odeg_wdata),
        .raddr(odeg_raddr), .rdata(odeg_rdata)
    );
    pgs_ram #(.W(ECNT_W), .D(MAX_NODES)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );
    pgs_ram #(.W(ECNT_W), .D(MAX_NODES)) u_fill_ram (
        .aclk(aclk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
        .raddr(fill_raddr), .rdata(fill_rdata)
    );
    pgs_ram #(.W(NODE_AW), .D(MAX_EDGES)) u_list_ram (
        .aclk(aclk), .we(list_we), .waddr(list_waddr), .wdata(src_reg),
        .raddr(j_reg[EDGE_AW-1:0]), .rdata(list_rdata)
    );
    pgs_ram #(.W(RANK_W), .D(MAX_NODES)) u_rank_ram (
        .aclk(aclk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
        .raddr(rank_raddr), .rdata(rank_rdata)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NCNT_W'(4096);
            damping_reg    <= DAMP_W'(55705);
            threshold_reg  <= RANK_W'(10737);
            max_iter_reg   <= ITER_W'(1000);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_wdata[NCNT_W-1:0];
                CFG_DAMPING:    damping_reg    <= cfg_wdata[DAMP_W-1:0];
                CFG_THRESHOLD:  threshold_reg  <= cfg_wdata[RANK_W-1:0];
                default:        max_iter_reg   <= cfg_wdata[ITER_W-1:0];
            endcase
        end
    end

    // sequencing counters, accumulators and results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg       <= '0;
            clr_reg         <= '0;
            k_reg           <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            rem_reg         <= '0;
            acc_reg         <= '0;
            sweeps_reg      <= '0;
            ok_reg          <= 1'b1;
            dm_reg          <= '0;
            stat_sweeps_reg <= '0;
            stat_change_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            unique case (cmd.step)
                S_CLEAR, S_CLEAR_OP: clr_reg <= clr_reg + NODE_AW'(1);
                S_IDLE: begin
                    if (cmd.accept) begin
                        src_reg        <= source_node;
                        res_rank_reg   <= '0;
                        res_status_reg <= STAT_OK;
                        unique case (status.op)
                            OP_ADD_EDGE: begin
                                if (!range_add) begin
                                    res_status_reg <= STAT_RANGE;
                                end else if (store_full) begin
                                    res_status_reg <= STAT_FULL;
                                end else begin
                                    total_reg <= total_reg + ECNT_W'(1);
                                end
                            end
                            OP_READ: begin
                                if (!status.read_ok) res_status_reg <= STAT_RANGE;
                            end
                            OP_CLEAR: begin
                                total_reg <= '0;
                                clr_reg   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ2: res_rank_reg <= rank_rdata;
                S_EDIV: if (div_done) e_reg <= div_quotient;
                S_TELE: begin
                    tele_reg <= tele_prod[DAMP_W+RANK_W-1:DAMP_W];
                    k_reg    <= '0;
                end
                S_INIT: begin
                    if (status.node_end) begin
                        k_reg <= '0;
                        i_reg <= '0;
                    end else begin
                        k_reg <= k_reg + NCNT_W'(1);
                    end
                end
                S_CNT1: begin
                    if (status.edge_end) begin
                        i_reg   <= '0;
                        k_reg   <= '0;
                        acc_reg <= '0;
                    end
                end
                S_CNT2, S_PLC2: begin
                    src_reg <= e_src;
                    tgt_reg <= e_tgt;
                    if (!status.edge_valid) i_reg <= i_reg + ECNT_W'(1);
                end
                S_CNT3, S_PLC3: i_reg <= i_reg + ECNT_W'(1);
                S_PFX1: begin
                    if (status.node_end) begin
                        k_reg <= '0;
                        i_reg <= '0;
                    end
                end
                S_PFX2: begin
                    acc_reg <= acc_reg + cnt_rdata;
                    k_reg   <= k_reg + NCNT_W'(1);
                end
                S_PLC1: begin
                    if (status.edge_end) begin
                        k_reg      <= '0;
                        j_reg      <= '0;
                        ok_reg     <= 1'b1;
                        worst_reg  <= '0;
                        ndang_reg  <= '0;
                        sweeps_reg <= '0;
                        dm_reg     <= '0;
                    end
                end
                S_W1: if (status.node_end) k_reg <= '0;
                S_W2: begin
                    old_reg <= rank_rdata;
                    rem_reg <= cnt_rdata;
                    sum_reg <= '0;
                end
                S_WDIV: if (div_done) ndang_reg <= ndang_reg + {1'b0, div_quotient};
                S_E3: begin
                    if (status.odeg_zero) begin
                        j_reg   <= j_reg + ECNT_W'(1);
                        rem_reg <= rem_reg - ECNT_W'(1);
                    end
                end
                S_EDIV2: begin
                    if (div_done) begin
                        sum_reg <= sum_reg + SUM_W'(div_quotient);
                        j_reg   <= j_reg + ECNT_W'(1);
                        rem_reg <= rem_reg - ECNT_W'(1);
                    end
                end
                S_FIN: ssat_reg <= sat32(sum_reg + SUM_W'(dm_reg));
                S_MUL: prod_reg <= damping_reg * ssat_reg;
                S_NV: begin
                    if (diff > worst_reg) worst_reg <= diff;
                    if (diff > threshold_reg) ok_reg <= 1'b0;
                    k_reg <= k_reg + NCNT_W'(1);
                end
                S_SWEEP_END: begin
                    dm_reg     <= sat32(SUM_W'(ndang_reg));
                    sweeps_reg <= sweeps_inc[ITER_W-1:0];
                    j_reg      <= '0;
                    ok_reg     <= 1'b1;
                    worst_reg  <= '0;
                    ndang_reg  <= '0;
                    if (status.sweep_done) begin
                        stat_sweeps_reg <= sweeps_inc[ITER_W-1:0];
                        stat_change_reg <= worst_reg;
                        res_status_reg  <= ok_reg ? STAT_OK : STAT_NOCONV;
                    end
                end
                default: ;
            endcase

            // result register: load on the response step, drop once taken
            if ((cmd.step == S_RESP) && out_free) begin
                m_tvalid_reg   <= 1'b1;
                out_status_reg <= res_status_reg;
                out_rank_reg   <= res_rank_reg;
                out_sweeps_reg <= stat_sweeps_reg;
                out_change_reg <= stat_change_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign res_status = out_status_reg;
    assign res_rank   = out_rank_reg;
    assign res_sweeps = out_sweeps_reg;
    assign res_change = out_change_reg;

endmodule

`default_nettype wire

// ----- hdl/pagerank_gauss_seidel_engine.sv -----
// Add edge and read rank take a second step (skipped if rejected) before the response;
// clear first walks the whole out-degree table. Run: a setup (reciprocal, in-list build),
//   then sweeps with a division per dangling node and per in-edge from a non-dangling node.
// Items are taken one at a time; the shared divider sets the sweep time.
// Reset: synchronous, active low; a clearing pass over all 4096 entries then zeroes the
//   out-degree table, with no item accepted until it ends. Config is taken always.
`default_nettype none

module pagerank_gauss_seidel_engine
    import pgs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // operation[1:0], source_node[13:2], target_node[25:14]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata   // status[1:0], rank_value[33:2], sweep_count[49:34],
                                       // max_change[81:50]
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    logic [1:0]        res_status;
    logic [RANK_W-1:0] res_rank;
    logic [ITER_W-1:0] res_sweeps;
    logic [RANK_W-1:0] res_change;

    // sequencing: one state machine drives every step of the datapath
    pgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    // unpack the input item; hold the result in the datapath's output register
    pgs_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (ctrl_cmd),
        .status      (dp_status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .operation   (s_tdata[1:0]),
        .source_node (s_tdata[13:2]),
        .target_node (s_tdata[25:14]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .res_status  (res_status),
        .res_rank    (res_rank),
        .res_sweeps  (res_sweeps),
        .res_change  (res_change)
    );

    assign m_tdata = {6'b0, res_change, res_sweeps, res_rank, res_status};

`ifndef SYNTHESIS
    // the divider only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_status.div_done |-> (ctrl_cmd.step == S_EDIV || ctrl_cmd.step == S_WDIV ||
                                ctrl_cmd.step == S_EDIV2))
        else $error("divider result arrived outside a wait step");

    // an accepted item always leaves the idle step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (ctrl_cmd.step != S_IDLE))
        else $error("accepted item did not advance the sequencer");

    // a result is only loaded from the response step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(ctrl_cmd.step) == S_RESP))
        else $error("result raised outside the response step");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_pagerank_gauss_seidel_engine.sv -----
// Self-checking testbench for the PageRank Gauss-Seidel engine: edge loads, runs,
// rank reads and graph clears are predicted in fixed point and compared per item.
// Depends on pgs_pkg and pagerank_gauss_seidel_engine only.
`default_nettype none

module tb_pagerank_gauss_seidel_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import pgs_pkg::*;

    localparam int IDLE_LIMIT = 1500000;  // cycles with no handshake before giving up

    typedef struct packed {
        logic [11:0] tgt;
        logic [11:0] src;
        logic [1:0]  op;
    } cmd_t;

    typedef struct {
        status_t     status;
        logic [31:0] rank_value;
        logic [15:0] sweeps;
        logic [31:0] change;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    pagerank_gauss_seidel_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    // ---------------- engine shadow state ----------------
    logic [12:0] nodes_reg = 13'd4096;
    logic [15:0] damp_reg  = 16'd55705;
    logic [31:0] thresh_reg = 32'd10737;
    logic [15:0] iter_reg  = 16'd1000;

    logic [31:0] rank_mem [MAX_NODES];
    int unsigned out_deg  [MAX_NODES];
    logic [11:0] edge_src [$];
    logic [11:0] edge_dst [$];
    logic [31:0] dangling = '0;
    logic [15:0] last_sweeps = '0;
    logic [31:0] last_change = '0;

    cmd_t    pending_cmds [$];
    answer_t expected_answers [$];

    int  failures = 0;
    int  runs_seen = 0, reads_seen = 0, edges_seen = 0, items_seen = 0;
    bit  gaps_on = 1'b0;

    initial begin
        for (int i = 0; i < MAX_NODES; i++) begin
            rank_mem[i] = '0;
            out_deg[i]  = 0;
        end
    end

    function automatic int unsigned live_nodes();
        if (nodes_reg == 0) return 1;
        if (nodes_reg > MAX_NODES) return MAX_NODES;
        return nodes_reg;
    endfunction

    // Reset ranks to 1/N, then sweep in place until every change is within threshold or the sweep cap is reached.
    function automatic bit converge_ranks();
        int unsigned     n, cap, sweeps, od;
        longint unsigned unit_rank, tele, acc, next_dang, nv;
        logic [31:0]     old, worst, diff;
        bit              ok, done;
        n = live_nodes();
        cap = (iter_reg == 0) ? 1 : iter_reg;
        unit_rank = (64'd1 << 30) / n;
        tele = ((64'd65536 - damp_reg) * unit_rank) >> 16;
        for (int k = 0; k < n; k++) rank_mem[k] = unit_rank[31:0];
        dangling = '0;
        sweeps = 0;
        worst = '0;
        done = 1'b0;
        while (!done && sweeps < cap) begin
            next_dang = 0;
            ok = 1'b1;
            worst = '0;
            for (int k = 0; k < n; k++) begin
                old = rank_mem[k];
                if (out_deg[k] == 0) next_dang += old / n;
                acc = 0;
                // only edges with both ends below N take part
                foreach (edge_dst[j]) begin
                    if (edge_dst[j] == k && edge_src[j] < n) begin
                        od = out_deg[edge_src[j]];
                        if (od != 0) acc += rank_mem[edge_src[j]] / od;
                    end
                end
                acc += dangling;
                if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                nv = ((damp_reg * acc) >> 16) + tele;
                if (nv > 64'hFFFF_FFFF) nv = 64'hFFFF_FFFF;
                rank_mem[k] = nv[31:0];
                diff = (nv[31:0] >= old) ? nv[31:0] - old : old - nv[31:0];
                if (diff > worst) worst = diff;
                if (diff > thresh_reg) ok = 1'b0;
            end
            dangling = (next_dang > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : next_dang[31:0];
            sweeps++;
            done = ok;
        end
        last_sweeps = sweeps[15:0];
        last_change = worst;
        return done;
    endfunction

    function automatic answer_t apply_item(cmd_t c);
        answer_t     a;
        int unsigned n;
        n = live_nodes();
        a.status = STAT_OK;
        a.rank_value = '0;
        case (op_t'(c.op))
            OP_ADD_EDGE: begin
                if (c.src >= n || c.tgt >= n) begin
                    a.status = STAT_RANGE;
                end else if (edge_src.size() >= MAX_EDGES) begin
                    a.status = STAT_FULL;
                end else begin
                    edge_src.push_back(c.src);
                    edge_dst.push_back(c.tgt);
                    out_deg[c.src]++;
                    edges_seen++;
                end
            end
            OP_RUN: begin
                a.status = converge_ranks() ? STAT_OK : STAT_NOCONV;
                runs_seen++;
            end
            OP_READ: begin
                if (c.tgt >= n) a.status = STAT_RANGE;
                else a.rank_value = rank_mem[c.tgt];
                reads_seen++;
            end
            default: begin
                edge_src.delete();
                edge_dst.delete();
                for (int i = 0; i < MAX_NODES; i++) out_deg[i] = 0;
            end
        endcase
        a.sweeps = last_sweeps;
        a.change = last_change;
        return a;
    endfunction

    function automatic int unsigned draw_gap();
        if (!gaps_on || $urandom_range(0, 1)) return 0;
        return $urandom_range(0, 16);
    endfunction

    // ---------------- driver: feed queued items, predict on acceptance ----------------
    int unsigned send_wait = 0;

    always @(posedge aclk) begin
        cmd_t        c;
        int unsigned g;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            expected_answers.push_back(apply_item(cmd_t'(s_tdata[25:0])));
            items_seen++;
            g = draw_gap();
            if (g == 0 && pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                s_tdata <= {6'b0, c.tgt, c.src, c.op};
            end else begin
                s_tvalid <= 1'b0;
                send_wait <= g;
            end
        end else if (!s_tvalid) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                s_tdata  <= {6'b0, c.tgt, c.src, c.op};
                s_tvalid <= 1'b1;
            end
        end
    end

    // ---------------- monitor: random back-pressure, compare fields ----------------
    int unsigned stall_left = 0;

    always @(posedge aclk) begin
        answer_t     want;
        int unsigned s;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            s = stall_left;
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $realtime, m_tdata);
                    failures++;
                end else begin
                    want = expected_answers.pop_front();
                    if (m_tdata[1:0] !== want.status || m_tdata[33:2] !== want.rank_value ||
                        m_tdata[49:34] !== want.sweeps || m_tdata[81:50] !== want.change) begin
                        $display("%0t: mismatch expected st=%0d rank=%h sw=%0d chg=%h",
                                 $realtime, want.status, want.rank_value, want.sweeps,
                                 want.change);
                        $display("%0t:          actual   st=%0d rank=%h sw=%0d chg=%h",
                                 $realtime, m_tdata[1:0], m_tdata[33:2], m_tdata[49:34],
                                 m_tdata[81:50]);
                        failures++;
                    end
                end
                s = draw_gap();
            end else if (s > 0) begin
                s--;
            end
            stall_left <= s;
            m_tready <= (s == 0);
        end
    end

    // ---------------- watchdog ----------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_item(op_t op, int unsigned src, int unsigned tgt);
        cmd_t c;
        c.op  = op;
        c.src = src[11:0];
        c.tgt = tgt[11:0];
        pending_cmds.push_back(c);
    endtask

    // Hold until every queued item is taken and answered, plus a short margin.
    // Sample on the falling edge so the driver's updates have settled.
    task automatic settle();
        while (pending_cmds.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_NODE_COUNT: nodes_reg  = val[12:0];
            CFG_DAMPING:    damp_reg   = val[15:0];
            CFG_THRESHOLD:  thresh_reg = val;
            default:        iter_reg   = val[15:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned n, ranked, live_edges, pick, span;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: widest graph, one-sweep cap, field extremes.
        write_reg(CFG_MAX_ITER, 0);
        write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(CFG_DAMPING, 16'hFFFF);
        queue_item(OP_ADD_EDGE, 4095, 0);
        queue_item(OP_ADD_EDGE, 0, 4095);
        queue_item(OP_ADD_EDGE, 4095, 4095);
        queue_item(OP_RUN, 0, 0);
        queue_item(OP_READ, 0, 4095);
        queue_item(OP_READ, 4095, 0);
        queue_item(OP_CLEAR, 4095, 4095);
        settle();

        // Directed: N of zero acts as one, stale edges, range errors.
        write_reg(CFG_NODE_COUNT, 0);
        write_reg(CFG_DAMPING, 0);
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_MAX_ITER, 1);
        queue_item(OP_ADD_EDGE, 0, 0);
        queue_item(OP_ADD_EDGE, 1, 0);
        queue_item(OP_ADD_EDGE, 0, 1);
        queue_item(OP_RUN, 0, 0);
        queue_item(OP_READ, 0, 0);
        queue_item(OP_READ, 0, 1);
        settle();
        write_reg(CFG_NODE_COUNT, 13'h1FFF);  // above the node limit, clamps
        queue_item(OP_ADD_EDGE, 4095, 17);
        queue_item(OP_READ, 0, 4095);
        queue_item(OP_READ, 0, 2048);
        settle();

        // Random phases: small graphs, varied settings, edges persist across N changes.
        ranked = 1;  // ranks are written for nodes below this count
        live_edges = 0;
        for (int p = 0; p < 6; p++) begin
            n = (p == 0) ? 1 : (p == 1) ? 64 : $urandom_range(2, 16);
            write_reg(CFG_NODE_COUNT, n);
            write_reg(CFG_DAMPING, (p == 2) ? 0 : (p == 3) ? 65535 : $urandom_range(0, 65535));
            write_reg(CFG_THRESHOLD, (p == 4) ? 0 : (p == 5) ? 32'hFFFF_FFFF :
                                     $urandom_range(0, 200000));
            write_reg(CFG_MAX_ITER, (p == 0) ? 0 : (p == 1) ? $urandom_range(1, 4) :
                                    $urandom_range(1, 15));
            gaps_on = (p != 2);
            for (int i = 0; i < 87; i++) begin
                pick = $urandom_range(0, 99);
                if (live_edges > 48 || pick < 2) begin
                    queue_item(OP_CLEAR, $urandom, $urandom);
                    live_edges = 0;
                end else if (pick < 7) begin
                    queue_item(OP_RUN, $urandom, $urandom);
                    if (n > ranked) ranked = n;
                end else if (pick < 27) begin
                    span = (n < ranked) ? n : ranked;
                    if ($urandom_range(0, 3) == 0)
                        queue_item(OP_READ, $urandom, $urandom_range(n, 4095));
                    else
                        queue_item(OP_READ, $urandom, $urandom_range(0, span - 1));
                end else if (pick < 35) begin
                    queue_item(OP_ADD_EDGE, $urandom, $urandom);  // mostly out of range
                end else begin
                    queue_item(OP_ADD_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
                    live_edges++;
                end
            end
            queue_item(OP_RUN, 0, 0);
            if (n > ranked) ranked = n;
            queue_item(OP_READ, 0, n - 1);
            settle();
        end

        $display("covered %0d items: %0d edges stored, %0d runs, %0d reads",
                 items_seen, edges_seen, runs_seen, reads_seen);
        $display("settings swept: N from 0 to 8191, damping and threshold at both ends");
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures", failures);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
